// File: src/ddd_pkg.sv
// ----------------------------------------------------------------------------
// ddd_pkg
// Shared types, constants and calendar functions of the date difference block.
// ----------------------------------------------------------------------------
`default_nettype none

package ddd_pkg;

   // Default number of entries in the queue between front and back.
   localparam int unsigned DefaultQueueDepth = 2;

   // Largest magnitude of the answer; larger differences saturate here.
   localparam int DiffMax = 4194303;

   // Multiplicative inverse of 25 modulo 2**14 and the divisibility bound.
   localparam logic [13:0] Inv25 = 14'd7209;
   localparam logic [13:0] Div25Bound = 14'd655;

   // Reciprocal of 100 for a 15-bit dividend: (x * Recip100) >> Recip100Shift.
   localparam logic [15:0] Recip100 = 16'd41944;
   localparam int unsigned Recip100Shift = 22;

   // One date, reduced to what the day-number arithmetic needs.
   // yy is the year counted from March, shifted up by 400.
   // doy is the day of that March-based year, 0 to 365 for a valid date.
   typedef struct packed {
      logic        err;
      logic [1:0][14:0] yy;
      logic [1:0][8:0]  doy;
   } entry_type;

   // Gregorian leap rule. Divisibility by 25 uses the modular inverse,
   // so y % 100 == 0 becomes (y % 4 == 0) && div25, and y % 400 == 0
   // becomes (y % 16 == 0) && div25.
   function automatic logic is_leap(input logic [13:0] y);
      logic [13:0] prod;
      logic        div25;
      prod  = 14'(y * Inv25);
      div25 = (prod <= Div25Bound);
      return ((y[1:0] == 2'd0) && !div25) || ((y[3:0] == 4'd0) && div25);
   endfunction

   // Last day of a month; months outside 1 to 12 give 0.
   function automatic logic [4:0] last_day(input logic [3:0] m, input logic leap);
      logic [4:0] d;
      unique case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: d = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    d = 5'd30;
         4'd2:                                       d = leap ? 5'd29 : 5'd28;
         default:                                    d = 5'd0;
      endcase
      return d;
   endfunction

   // Days before the first of a month in a year that starts on March 1.
   function automatic logic [8:0] month_offset(input logic [3:0] m);
      logic [8:0] o;
      unique case (m)
         4'd3:    o = 9'd0;
         4'd4:    o = 9'd31;
         4'd5:    o = 9'd61;
         4'd6:    o = 9'd92;
         4'd7:    o = 9'd122;
         4'd8:    o = 9'd153;
         4'd9:    o = 9'd184;
         4'd10:   o = 9'd214;
         4'd11:   o = 9'd245;
         4'd12:   o = 9'd275;
         4'd1:    o = 9'd306;
         4'd2:    o = 9'd337;
         default: o = 9'd0;
      endcase
      return o;
   endfunction

endpackage

`default_nettype wire

// File: src/ddd_front.sv
// ----------------------------------------------------------------------------
// ddd_front
// Accepts date pairs, checks them and reduces each date for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_front (
   input  wire logic               req_tvalid,
   output logic                    req_tready,
   input  wire logic [47:0]        req_tdata,
   input  wire logic               queue_full,
   output logic                    queue_push,
   output ddd_pkg::entry_type      queue_entry
);
   import ddd_pkg::*;

   logic [1:0][4:0]  day;
   logic [1:0][3:0]  month;
   logic [1:0][13:0] year;
   logic [1:0]       valid;

   assign day[0]   = req_tdata[4:0];
   assign month[0] = req_tdata[8:5];
   assign year[0]  = req_tdata[22:9];
   assign day[1]   = req_tdata[27:23];
   assign month[1] = req_tdata[31:28];
   assign year[1]  = req_tdata[45:32];

   always_comb begin
      for (int i = 0; i < 2; i++) begin
         valid[i] = (month[i] >= 4'd1) && (month[i] <= 4'd12) && (day[i] != 5'd0) &&
                    (day[i] <= last_day(month[i], is_leap(year[i])));
         // January and February belong to the previous March-based year.
         queue_entry.yy[i]  = {1'b0, year[i]} + 15'd400 - 15'(month[i] <= 4'd2);
         queue_entry.doy[i] = month_offset(month[i]) + 9'(day[i]) - 9'd1;
      end
      queue_entry.err = !(valid[0] && valid[1]);
   end

   assign req_tready = !queue_full;
   assign queue_push = req_tvalid && !queue_full;

endmodule

`default_nettype wire

// File: src/ddd_queue.sv
// ----------------------------------------------------------------------------
// ddd_queue
// Small first-in first-out queue of reduced date pairs.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_queue #(
   parameter int unsigned Depth = ddd_pkg::DefaultQueueDepth
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire ddd_pkg::entry_type push_entry,
   output logic                    full,
   input  wire logic               pop,
   output logic                    empty,
   output ddd_pkg::entry_type      head
);
   import ddd_pkg::*;

   localparam int unsigned PtrW   = $clog2(Depth);
   localparam int unsigned CountW = $clog2(Depth + 1);

   entry_type         mem_ff [Depth];
   logic [PtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountW-1:0] count_ff, count_in;

   assign full  = (count_ff == CountW'(Depth));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + PtrW'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + PtrW'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CountW'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CountW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CountW'(Depth))
      else $error("queue count above depth");

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && full) && !(pop && empty))
      else $error("queue pushed when full or popped when empty");

   a_pop_drains: assert property (@(posedge clock) disable iff (reset)
      (pop && !push) |=> (count_ff == $past(count_ff) - CountW'(1)))
      else $error("queue count did not drop after a pop");

endmodule

`default_nettype wire

// File: src/ddd_back.sv
// ----------------------------------------------------------------------------
// ddd_back
// Pipelined day-number arithmetic, difference, end-day and saturation.
// ----------------------------------------------------------------------------
`default_nettype none

module ddd_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               count_end_day,
   input  wire logic               queue_empty,
   input  wire ddd_pkg::entry_type queue_head,
   output logic                    queue_pop,
   output logic                    rsp_tvalid,
   input  wire logic               rsp_tready,
   output logic [23:0]             rsp_tdata,
   output logic                    rsp_tuser
);
   import ddd_pkg::*;

   // Stage two: products and quotients of each date.
   logic             s2_valid_ff, s2_valid_in;
   logic             s2_err_ff;
   logic [1:0][22:0] s2_p365_ff, s2_p365_in;
   logic [1:0][12:0] s2_q4_ff, s2_q4_in;
   logic [1:0][7:0]  s2_q100_ff, s2_q100_in;
   logic [1:0][8:0]  s2_doy_ff;

   // Stage three: signed difference of the day numbers.
   logic               s3_valid_ff, s3_valid_in;
   logic               s3_err_ff;
   logic signed [23:0] s3_diff_ff, s3_diff_in;

   // Output register.
   logic        out_valid_ff, out_valid_in;
   logic        out_err_ff;
   logic [22:0] out_data_ff, out_data_in;

   logic out_adv, s3_adv, s2_adv;
   logic [30:0]      prod100 [2];
   logic [1:0][22:0] day_num;
   logic signed [24:0] adj;

   assign out_adv   = !out_valid_ff || rsp_tready;
   assign s3_adv    = !s3_valid_ff || out_adv;
   assign s2_adv    = !s2_valid_ff || s3_adv;
   assign queue_pop = !queue_empty && s2_adv;

   // Products of the queue head.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         s2_p365_in[i] = 23'(24'(queue_head.yy[i]) * 24'd365);
         s2_q4_in[i]   = queue_head.yy[i][14:2];
         prod100[i]    = 31'(queue_head.yy[i]) * 31'(Recip100);
         s2_q100_in[i] = prod100[i][Recip100Shift+7:Recip100Shift];
      end
   end

   // Day number = yy*365 + yy/4 - yy/100 + yy/400 + doy, with yy/400 = (yy/100)/4.
   always_comb begin
      for (int i = 0; i < 2; i++) begin
         day_num[i] = s2_p365_ff[i] + 23'(s2_q4_ff[i]) - 23'(s2_q100_ff[i]) +
                      23'(s2_q100_ff[i][7:2]) + 23'(s2_doy_ff[i]);
      end
      s3_diff_in = signed'(24'(day_num[1]) - 24'(day_num[0]));
   end

   // End day, zero result on error, and saturation.
   always_comb begin
      adj = {s3_diff_ff[23], s3_diff_ff};
      if (count_end_day) begin
         if (s3_diff_ff[23]) begin
            adj = adj - 25'sd1;
         end else begin
            adj = adj + 25'sd1;
         end
      end
      if (s3_err_ff) begin
         out_data_in = '0;
      end else if (adj > 25'(DiffMax)) begin
         out_data_in = 23'(DiffMax);
      end else if (adj < -25'(DiffMax)) begin
         out_data_in = 23'(-DiffMax);
      end else begin
         out_data_in = adj[22:0];
      end
   end

   always_comb begin
      s2_valid_in  = s2_adv ? queue_pop : s2_valid_ff;
      s3_valid_in  = s3_adv ? s2_valid_ff : s3_valid_ff;
      out_valid_in = out_adv ? s3_valid_ff : out_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff  <= s2_valid_in;
         s3_valid_ff  <= s3_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (queue_pop) begin
         s2_p365_ff <= s2_p365_in;
         s2_q4_ff   <= s2_q4_in;
         s2_q100_ff <= s2_q100_in;
         s2_doy_ff  <= queue_head.doy;
         s2_err_ff  <= queue_head.err;
      end
      if (s3_adv && s2_valid_ff) begin
         s3_diff_ff <= s3_diff_in;
         s3_err_ff  <= s2_err_ff;
      end
      if (out_adv && s3_valid_ff) begin
         out_data_ff <= out_data_in;
         out_err_ff  <= s3_err_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};
   assign rsp_tuser  = out_err_ff;

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_err_ff) |-> (out_data_ff == '0))
      else $error("error result carries a nonzero difference");

   a_saturated: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_data_ff != 23'h400000))
      else $error("difference beyond the saturation limit");

   a_s2_holds: assert property (@(posedge clock) disable iff (reset)
      (s2_valid_ff && !s3_adv) |=> (s2_valid_ff && $stable(s2_p365_ff)))
      else $error("stalled stage two lost its contents");

endmodule

`default_nettype wire

// File: src/date_day_difference.sv
// ----------------------------------------------------------------------------
// date_day_difference
// Signed number of days between two Gregorian dates.
// ----------------------------------------------------------------------------
// Each transfer on the req_ channel carries two dates; each transfer on the
// rsp_ channel returns the signed day count from the first date to the
// second, one result per request in order. The block accepts a new pair
// every clock cycle while its queue is not full. The front end checks both
// dates and reduces them, a short queue decouples it from the back end, and
// the back end runs a three-register pipeline (products, day numbers and
// difference, saturation) in which a stage holds while the stage after it
// is full and stalled by the rsp_ side. Leap years follow the 4/100/400 rule;
// year 0 counts as a leap year. A date with a month outside 1 to 12 or a day
// outside its month sets rsp_tuser and returns a difference of zero. With
// count_end_day set, the magnitude grows by one (equal dates give +1).
// Differences beyond +/-4194303 saturate there. Write csr_wdata only while
// no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module date_day_difference #(
   parameter int unsigned QueueDepth = ddd_pkg::DefaultQueueDepth
) (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_tvalid,
   output logic             req_tready,
   // [4:0] first_day, [8:5] first_month, [22:9] first_year,
   // [27:23] second_day, [31:28] second_month, [45:32] second_year, rest zero
   input  wire logic [47:0] req_tdata,

   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [22:0] day_difference (two's complement), [23] zero
   output logic [23:0]      rsp_tdata,
   // [0] date_error
   output logic             rsp_tuser,

   input  wire logic        csr_we,
   input  wire logic [0:0]  csr_wdata
);
   import ddd_pkg::*;

   // Mode register: count the end day.
   logic count_end_day_ff, count_end_day_in;

   logic      queue_full;
   logic      queue_push;
   logic      queue_empty;
   logic      queue_pop;
   entry_type queue_entry;
   entry_type queue_head;

   assign count_end_day_in = csr_we ? csr_wdata[0] : count_end_day_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_end_day_ff <= 1'b0;
      end else begin
         count_end_day_ff <= count_end_day_in;
      end
   end

   // Front end: accepts a pair, validates it and reduces both dates.
   ddd_front u_front (
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .queue_full  (queue_full),
      .queue_push  (queue_push),
      .queue_entry (queue_entry)
   );

   // The queue lets the front keep accepting while the back end is stalled.
   ddd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_entry (queue_entry),
      .full       (queue_full),
      .pop        (queue_pop),
      .empty      (queue_empty),
      .head       (queue_head)
   );

   // Back end: day numbers, difference, end day, saturation, output register.
   ddd_back u_back (
      .clock         (clock),
      .reset         (reset),
      .count_end_day (count_end_day_ff),
      .queue_empty   (queue_empty),
      .queue_head    (queue_head),
      .queue_pop     (queue_pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

`default_nettype wire
